@@ src/cas_pkg.sv @@
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants for the clock / alarm / stopwatch block
// Field widths, rollover limits, command codes and the beat structs that pass
// between the register file, the time core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_pkg;

	// Field widths
	localparam int HOUR_W   = 5;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int TENTH_W  = 4;
	localparam int CNT_W    = 5;
	localparam int KIND_W   = 3;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;
	localparam int RIDX_W   = 2;

	// Prescaler reload and rollover limits
	localparam logic [CNT_W-1:0]   TICKS_PER_SECOND = CNT_W'(21);
	localparam logic [HOUR_W-1:0]  HOUR_LAST   = HOUR_W'(23);
	localparam logic [MIN_W-1:0]   MIN_LAST    = MIN_W'(59);
	localparam logic [SEC_W-1:0]   SEC_LAST    = SEC_W'(59);
	localparam logic [TENTH_W-1:0] TENTH_LAST  = TENTH_W'(9);

	// Command codes carried in the kind field
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK      = 3'd0,
		KIND_SET_TIME  = 3'd1,
		KIND_SW_CLEAR  = 3'd2,
		KIND_SW_TOGGLE = 3'd3,
		KIND_SW_ENTER  = 3'd4,
		KIND_SW_LEAVE  = 3'd5
	} kind_t;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [RIDX_W-1:0] {
		REG_ALARM_HOUR   = 2'd0,
		REG_ALARM_MINUTE = 2'd1,
		REG_ALARM_ENABLE = 2'd2
	} reg_idx_t;

	// Alarm configuration
	typedef struct packed {
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic              enable;
	} alarm_cfg_t;

	// One input beat
	typedef struct packed {
		kind_t             kind;
		logic [HOUR_W-1:0] set_hour;
		logic [MIN_W-1:0]  set_minute;
		logic [SEC_W-1:0]  set_second;
	} item_t;

	// One result beat
	typedef struct packed {
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
		logic               blink;
		logic [HOUR_W-1:0]  sw_hour;
		logic [MIN_W-1:0]   sw_minute;
		logic [SEC_W-1:0]   sw_second;
		logic [TENTH_W-1:0] sw_tenth;
		logic               sw_mode_on;
		logic               sw_running;
		logic               alarm_match;
	} result_t;

endpackage

`default_nettype wire

@@ src/cas_apb_regs.sv @@
// ----------------------------------------------------------------------------
// cas_apb_regs: alarm configuration registers
// APB-style slave holding alarm hour, alarm minute and alarm enable.
// Writes land in the access phase; reads are returned with zero wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_apb_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [cas_pkg::ADDR_W-1:0] paddr,
	input  wire logic [cas_pkg::DATA_W-1:0] pwdata,
	output logic      [cas_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output cas_pkg::alarm_cfg_t             cfg
);
	import cas_pkg::*;

	alarm_cfg_t cfg_q;
	reg_idx_t   idx;
	logic       wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_ALARM_HOUR:   cfg_q.hour   <= pwdata[HOUR_W-1:0];
				REG_ALARM_MINUTE: cfg_q.minute <= pwdata[MIN_W-1:0];
				REG_ALARM_ENABLE: cfg_q.enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_ALARM_HOUR:   prdata = DATA_W'(cfg_q.hour);
			REG_ALARM_MINUTE: prdata = DATA_W'(cfg_q.minute);
			REG_ALARM_ENABLE: prdata = DATA_W'(cfg_q.enable);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ src/cas_time_core.sv @@
// ----------------------------------------------------------------------------
// cas_time_core: clock, stopwatch and prescaler state
// Applies one command beat per step to the time-of-day and stopwatch counters.
// The state registers double as the result register seen on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_time_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  cas_pkg::item_t           item,
	input  cas_pkg::alarm_cfg_t      cfg,
	output cas_pkg::result_t         res
);
	import cas_pkg::*;

	result_t           res_q, res_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              sw_adv;

	// Stopwatch advances on even prescaler values while mode and run are set
	assign sw_adv = res_q.sw_mode_on && res_q.sw_running && !cnt_q[0];

	// Next-state logic
	always_comb begin
		res_d = res_q;
		cnt_d = cnt_q;
		case (item.kind)
			KIND_TICK: begin
				if (sw_adv) begin
					if (res_q.sw_tenth != TENTH_LAST) begin
						res_d.sw_tenth = res_q.sw_tenth + 1'b1;
					end else begin
						res_d.sw_tenth = '0;
						if (res_q.sw_second != SEC_LAST) begin
							res_d.sw_second = res_q.sw_second + 1'b1;
						end else begin
							res_d.sw_second = '0;
							if (res_q.sw_minute != MIN_LAST) begin
								res_d.sw_minute = res_q.sw_minute + 1'b1;
							end else begin
								res_d.sw_minute = '0;
								res_d.sw_hour = (res_q.sw_hour >= HOUR_LAST) ? '0 :
									res_q.sw_hour + 1'b1;
							end
						end
					end
				end
				if (cnt_q <= CNT_W'(1)) begin
					cnt_d       = TICKS_PER_SECOND;
					res_d.blink = !res_q.blink;
					if (res_q.second != SEC_LAST) begin
						res_d.second = res_q.second + 1'b1;
					end else begin
						res_d.second = '0;
						if (res_q.minute != MIN_LAST) begin
							res_d.minute = res_q.minute + 1'b1;
						end else begin
							res_d.minute = '0;
							res_d.hour = (res_q.hour >= HOUR_LAST) ? '0 : res_q.hour + 1'b1;
						end
					end
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			KIND_SET_TIME: begin
				res_d.hour   = (item.set_hour   > HOUR_LAST) ? '0 : item.set_hour;
				res_d.minute = (item.set_minute > MIN_LAST)  ? '0 : item.set_minute;
				res_d.second = (item.set_second > SEC_LAST)  ? '0 : item.set_second;
			end
			KIND_SW_CLEAR: begin
				res_d.sw_hour   = '0;
				res_d.sw_minute = '0;
				res_d.sw_second = '0;
				res_d.sw_tenth  = '0;
			end
			KIND_SW_TOGGLE: res_d.sw_running = !res_q.sw_running;
			KIND_SW_ENTER:  res_d.sw_mode_on = 1'b1;
			KIND_SW_LEAVE: begin
				if (!res_q.sw_running) res_d.sw_mode_on = 1'b0;
			end
			default: ;
		endcase
		// Alarm compare on the updated time
		res_d.alarm_match = cfg.enable && (res_d.hour == cfg.hour) &&
			(res_d.minute == cfg.minute);
	end

	// State / result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
			cnt_q <= TICKS_PER_SECOND;
		end else if (step) begin
			res_q <= res_d;
			cnt_q <= cnt_d;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

@@ src/clock_alarm_stopwatch_top.sv @@
// ----------------------------------------------------------------------------
// clock_alarm_stopwatch_top: 24-hour clock with alarm match and stopwatch
// Usage:
//   Input channel (in_valid/in_ready): one beat carries a command kind and the
//   set_* values used by the set-time command. Tick beats drive a prescaler;
//   every 21 ticks one second passes on the clock and blink toggles.
//   Output channel (out_valid/out_ready): one result beat per input beat with
//   the clock, stopwatch, mode/run flags and the alarm match.
//   Config: APB-style port, alarm hour at 0x0, minute at 0x4, enable at 0x8.
//   Throughput: one beat per cycle unless stalled; input register feeds one
//   pass of counter logic into the result register.
//   Stall: while out_ready is low the result holds; one more beat can wait in
//   the input register, after which in_ready drops.
//   Reset: arst_n clears both channels, the clock and stopwatch to zero, the
//   prescaler to 21 and all alarm registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_alarm_stopwatch_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [cas_pkg::KIND_W-1:0]  kind,
	input  wire logic [cas_pkg::HOUR_W-1:0]  set_hour,
	input  wire logic [cas_pkg::MIN_W-1:0]   set_minute,
	input  wire logic [cas_pkg::SEC_W-1:0]   set_second,
	// output channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [cas_pkg::HOUR_W-1:0]  hour,
	output logic      [cas_pkg::MIN_W-1:0]   minute,
	output logic      [cas_pkg::SEC_W-1:0]   second,
	output logic                             blink,
	output logic      [cas_pkg::HOUR_W-1:0]  sw_hour,
	output logic      [cas_pkg::MIN_W-1:0]   sw_minute,
	output logic      [cas_pkg::SEC_W-1:0]   sw_second,
	output logic      [cas_pkg::TENTH_W-1:0] sw_tenth,
	output logic                             sw_mode_on,
	output logic                             sw_running,
	output logic                             alarm_match,
	// config port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [cas_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [cas_pkg::DATA_W-1:0]  pwdata,
	output logic      [cas_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);
	import cas_pkg::*;

	alarm_cfg_t cfg;
	item_t      item_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       adv;
	logic       step;
	result_t    res;

	// Flow control: result slot frees when empty or taken
	assign adv      = !out_valid_q || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind       <= kind_t'(kind);
			item_s1.set_hour   <= set_hour;
			item_s1.set_minute <= set_minute;
			item_s1.set_second <= set_second;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	cas_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cas_time_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Output fields
	assign out_valid   = out_valid_q;
	assign hour        = res.hour;
	assign minute      = res.minute;
	assign second      = res.second;
	assign blink       = res.blink;
	assign sw_hour     = res.sw_hour;
	assign sw_minute   = res.sw_minute;
	assign sw_second   = res.sw_second;
	assign sw_tenth    = res.sw_tenth;
	assign sw_mode_on  = res.sw_mode_on;
	assign sw_running  = res.sw_running;
	assign alarm_match = res.alarm_match;

endmodule

`default_nettype wire

@@ src/cas_checker.sv @@
// ----------------------------------------------------------------------------
// cas_checker: port-level checks for clock_alarm_stopwatch_top
// Watches the channels and result fields; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module cas_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [cas_pkg::HOUR_W-1:0]  hour,
	input wire logic [cas_pkg::MIN_W-1:0]   minute,
	input wire logic [cas_pkg::SEC_W-1:0]   second,
	input wire logic [cas_pkg::HOUR_W-1:0]  sw_hour,
	input wire logic [cas_pkg::MIN_W-1:0]   sw_minute,
	input wire logic [cas_pkg::SEC_W-1:0]   sw_second,
	input wire logic [cas_pkg::TENTH_W-1:0] sw_tenth
);
	import cas_pkg::*;

	// Stalled result beat stays put
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hour) && $stable(minute) &&
			$stable(second) && $stable(sw_tenth))
		else $error("result beat changed while stalled");

	// Input side never blocks while the result slot is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low with empty result slot");

	// Clock time stays in range
	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hour <= HOUR_LAST && minute <= MIN_LAST && second <= SEC_LAST)
		else $error("clock time out of range");

	// Stopwatch stays in range
	a_sw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sw_hour <= HOUR_LAST && sw_minute <= MIN_LAST &&
			sw_second <= SEC_LAST && sw_tenth <= TENTH_LAST)
		else $error("stopwatch value out of range");

endmodule

bind clock_alarm_stopwatch_top cas_checker u_cas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.hour      (hour),
	.minute    (minute),
	.second    (second),
	.sw_hour   (sw_hour),
	.sw_minute (sw_minute),
	.sw_second (sw_second),
	.sw_tenth  (sw_tenth)
);

`default_nettype wire

@@ tb/sv/cas_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// cas_tb_pkg: expected-result tracking for the clock / alarm / stopwatch block
// Holds a cycle-free copy of the time keeping (prescaler, clock, stopwatch,
// alarm registers), turns each accepted command beat into the result beat it
// should cause, and compares result beats field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

package cas_tb_pkg;

	import cas_pkg::*;

	// Kind codes the block has no command for
	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	// Only this many failures get a full report line
	localparam int REPORT_LIMIT = 10;

	// Command beat as driven; kind kept raw so the spare codes fit
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [HOUR_W-1:0] set_hour;
		logic [MIN_W-1:0]  set_minute;
		logic [SEC_W-1:0]  set_second;
	} cmd_beat_t;

	class alarm_watch_scoreboard;

		// alarm registers
		logic [HOUR_W-1:0]  alarm_h;
		logic [MIN_W-1:0]   alarm_m;
		logic               alarm_en;

		// time keeping
		logic [CNT_W-1:0]   prescale;
		logic [HOUR_W-1:0]  tod_h;
		logic [MIN_W-1:0]   tod_m;
		logic [SEC_W-1:0]   tod_s;
		logic               blink_q;
		logic [HOUR_W-1:0]  sw_h;
		logic [MIN_W-1:0]   sw_m;
		logic [SEC_W-1:0]   sw_s;
		logic [TENTH_W-1:0] sw_t;
		logic               sw_mode;
		logic               sw_run;

		// results still owed by the block, oldest first
		result_t owed_results[$];

		int mismatches;
		int checked;
		int matches_seen;
		int midnights;

		function new();
			alarm_h  = '0;
			alarm_m  = '0;
			alarm_en = 1'b0;
			prescale = TICKS_PER_SECOND;
			tod_h    = '0;
			tod_m    = '0;
			tod_s    = '0;
			blink_q  = 1'b0;
			sw_h     = '0;
			sw_m     = '0;
			sw_s     = '0;
			sw_t     = '0;
			sw_mode  = 1'b0;
			sw_run   = 1'b0;
			mismatches   = 0;
			checked      = 0;
			matches_seen = 0;
			midnights    = 0;
		endfunction

		// Register write as seen at the access edge
		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_ALARM_HOUR:   alarm_h  = value[HOUR_W-1:0];
				REG_ALARM_MINUTE: alarm_m  = value[MIN_W-1:0];
				REG_ALARM_ENABLE: alarm_en = value[0];
				default: ;
			endcase
		endfunction

		// Stopwatch: tenths carry into s, m, h; hours wrap at 24
		function void advance_watch();
			if (sw_t != TENTH_LAST) begin
				sw_t++;
				return;
			end
			sw_t = '0;
			if (sw_s != SEC_LAST) begin
				sw_s++;
				return;
			end
			sw_s = '0;
			if (sw_m != MIN_LAST) begin
				sw_m++;
				return;
			end
			sw_m = '0;
			sw_h = (sw_h == HOUR_LAST) ? '0 : sw_h + 1'b1;
		endfunction

		// One second on the clock
		function void advance_clock();
			blink_q = ~blink_q;
			if (tod_s != SEC_LAST) begin
				tod_s++;
				return;
			end
			tod_s = '0;
			if (tod_m != MIN_LAST) begin
				tod_m++;
				return;
			end
			tod_m = '0;
			if (tod_h == HOUR_LAST) begin
				tod_h = '0;
				midnights++;
			end else begin
				tod_h++;
			end
		endfunction

		// Timer tick: stopwatch looks at the prescaler before it counts down
		function void tick();
			if (sw_mode && sw_run && !prescale[0])
				advance_watch();
			if (prescale <= 1) begin
				prescale = TICKS_PER_SECOND;
				advance_clock();
			end else begin
				prescale--;
			end
		endfunction

		// Accepted command beat: update state, queue the result it causes
		function void note_item(cmd_beat_t b);
			result_t want;
			case (b.kind)
				KIND_TICK: tick();
				KIND_SET_TIME: begin
					// out-of-range values load zero
					tod_h = (b.set_hour > HOUR_LAST) ? '0 : b.set_hour;
					tod_m = (b.set_minute > MIN_LAST) ? '0 : b.set_minute;
					tod_s = (b.set_second > SEC_LAST) ? '0 : b.set_second;
				end
				KIND_SW_CLEAR: begin
					sw_h = '0;
					sw_m = '0;
					sw_s = '0;
					sw_t = '0;
				end
				KIND_SW_TOGGLE: sw_run = ~sw_run;
				KIND_SW_ENTER:  sw_mode = 1'b1;
				// leaving only takes effect while stopped
				KIND_SW_LEAVE:  if (!sw_run) sw_mode = 1'b0;
				default: ;
			endcase
			want.hour        = tod_h;
			want.minute      = tod_m;
			want.second      = tod_s;
			want.blink       = blink_q;
			want.sw_hour     = sw_h;
			want.sw_minute   = sw_m;
			want.sw_second   = sw_s;
			want.sw_tenth    = sw_t;
			want.sw_mode_on  = sw_mode;
			want.sw_running  = sw_run;
			want.alarm_match = alarm_en && (tod_h == alarm_h) && (tod_m == alarm_m);
			if (want.alarm_match)
				matches_seen++;
			owed_results.push_back(want);
		endfunction

		function void note_failure(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch: %s", msg);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				note_failure($sformatf("result %0d %s: expected %0d, got %0d",
					checked, name, want, got));
		endfunction

		// Result beat from the block against the oldest one owed
		function void check_result(result_t got);
			result_t want;
			if (owed_results.size() == 0) begin
				note_failure("result beat with nothing expected");
				return;
			end
			want = owed_results.pop_front();
			check_field("hour",        want.hour,        got.hour);
			check_field("minute",      want.minute,      got.minute);
			check_field("second",      want.second,      got.second);
			check_field("blink",       want.blink,       got.blink);
			check_field("sw_hour",     want.sw_hour,     got.sw_hour);
			check_field("sw_minute",   want.sw_minute,   got.sw_minute);
			check_field("sw_second",   want.sw_second,   got.sw_second);
			check_field("sw_tenth",    want.sw_tenth,    got.sw_tenth);
			check_field("sw_mode_on",  want.sw_mode_on,  got.sw_mode_on);
			check_field("sw_running",  want.sw_running,  got.sw_running);
			check_field("alarm_match", want.alarm_match, got.alarm_match);
			checked++;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

	endclass

endpackage

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for clock_alarm_stopwatch_top
// Drives command beats (ticks, set-time, stopwatch commands, spare codes) with
// bursty input and a stalling output side, writes the alarm registers between
// phases, and checks every result beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import cas_pkg::*;
	import cas_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 64;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BEATS   = 100;

	// Output-side stall patterns
	typedef enum int {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [KIND_W-1:0]    kind;
	logic [HOUR_W-1:0]    set_hour;
	logic [MIN_W-1:0]     set_minute;
	logic [SEC_W-1:0]     set_second;
	logic                 out_valid;
	logic                 out_ready;
	logic [HOUR_W-1:0]    hour;
	logic [MIN_W-1:0]     minute;
	logic [SEC_W-1:0]     second;
	logic                 blink;
	logic [HOUR_W-1:0]    sw_hour;
	logic [MIN_W-1:0]     sw_minute;
	logic [SEC_W-1:0]     sw_second;
	logic [TENTH_W-1:0]   sw_tenth;
	logic                 sw_mode_on;
	logic                 sw_running;
	logic                 alarm_match;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	result_t              seen_result;
	alarm_watch_scoreboard sb;

	int  cycles      = 0;
	int  burst_left  = 0;
	bit  full_rate   = 1'b0;
	bit  hold_req    = 1'b0;
	int  holds_done  = 0;
	int  n_ticks     = 0;
	int  n_sets      = 0;
	int  n_cmds      = 0;
	int  n_spare     = 0;
	int  n_settings  = 0;

	clock_alarm_stopwatch_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.set_hour    (set_hour),
		.set_minute  (set_minute),
		.set_second  (set_second),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.blink       (blink),
		.sw_hour     (sw_hour),
		.sw_minute   (sw_minute),
		.sw_second   (sw_second),
		.sw_tenth    (sw_tenth),
		.sw_mode_on  (sw_mode_on),
		.sw_running  (sw_running),
		.alarm_match (alarm_match),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	assign seen_result = {hour, minute, second, blink, sw_hour, sw_minute, sw_second,
		sw_tenth, sw_mode_on, sw_running, alarm_match};

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results owed", cycles, sb.pending());
				$display("status: fail");
				$finish;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(seen_result);
	end

	// Output side: stall patterns, plus a long hold-off on request
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		mode      = RX_OPEN;
		mode_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk) out_ready <= 1'b0;
				hold_req = 1'b0;
				holds_done++;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN:  out_ready <= 1'b1;
					RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
					RX_HEAVY: out_ready <= ($urandom_range(0, 9) < 3);
					default:  out_ready <= ((cycles % 5) != 0);
				endcase
			end
		end
	end

	function automatic cmd_beat_t mk(input logic [KIND_W-1:0] k, input logic [HOUR_W-1:0] h,
		input logic [MIN_W-1:0] m, input logic [SEC_W-1:0] s);
		cmd_beat_t b;
		b.kind       = k;
		b.set_hour   = h;
		b.set_minute = m;
		b.set_second = s;
		return b;
	endfunction

	// Beat of the given kind with random set fields
	function automatic cmd_beat_t rand_beat(input logic [KIND_W-1:0] k);
		return mk(k, HOUR_W'($urandom_range(0, 31)), MIN_W'($urandom_range(0, 63)),
			SEC_W'($urandom_range(0, 63)));
	endfunction

	// Set-time beat, biased toward rollover and the alarm time
	function automatic cmd_beat_t set_beat();
		cmd_beat_t b;
		int        r;
		b = rand_beat(KIND_SET_TIME);
		r = $urandom_range(0, 99);
		if (r < 30) begin
			b.set_hour   = ($urandom_range(0, 1) != 0) ? HOUR_LAST :
				HOUR_W'($urandom_range(0, 23));
			b.set_minute = MIN_LAST;
			b.set_second = SEC_W'($urandom_range(55, 59));
		end else if (r < 60) begin
			b.set_hour   = sb.alarm_h;
			b.set_minute = sb.alarm_m - MIN_W'($urandom_range(0, 1));
			b.set_second = SEC_W'($urandom_range(45, 59));
		end
		return b;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [DATA_W-1:0] junk_above(input int w);
		logic [DATA_W-1:0] r;
		r = $urandom;
		if ($urandom_range(0, 1) == 0)
			return '0;
		return (r >> w) << w;
	endfunction

	// Offer one beat; bursts with gaps unless full_rate is set
	task automatic push_item(input cmd_beat_t b);
		int gap;
		if (!full_rate && burst_left <= 0) begin
			gap = pick_gap();
			repeat (gap) @(negedge clk) in_valid <= 1'b0;
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		kind       <= b.kind;
		set_hour   <= b.set_hour;
		set_minute <= b.set_minute;
		set_second <= b.set_second;
		do @(posedge clk); while (!in_ready);
		sb.note_item(b);
		burst_left--;
		case (b.kind)
			KIND_TICK:                    n_ticks++;
			KIND_SET_TIME:                n_sets++;
			KIND_SPARE_LO, KIND_SPARE_HI: n_spare++;
			default:                      n_cmds++;
		endcase
	endtask

	// Stop offering and wait for every owed result
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Register write: setup phase, then access phase
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Alarm setting; upper data bits sometimes carry junk
	task automatic configure(input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m,
		input logic en);
		write_reg(REG_ALARM_HOUR, DATA_W'(h) | junk_above(HOUR_W));
		write_reg(REG_ALARM_MINUTE, DATA_W'(m) | junk_above(MIN_W));
		write_reg(REG_ALARM_ENABLE, DATA_W'(en) | junk_above(1));
		n_settings++;
	endtask

	// Extremes, every command and the corner behaviors
	task automatic run_directed();
		push_item(mk(KIND_TICK, '0, '0, '0));
		push_item(mk(KIND_SET_TIME, HOUR_LAST, MIN_LAST, SEC_LAST));
		// all ones, then one past each limit: both load zero
		push_item(mk(KIND_SET_TIME, '1, '1, '1));
		push_item(mk(KIND_SET_TIME, HOUR_LAST + 1'b1, MIN_LAST + 1'b1, SEC_LAST + 1'b1));
		push_item(mk(KIND_SET_TIME, HOUR_W'(12), MIN_W'(34), SEC_W'(56)));
		// run and clear while not in stopwatch mode
		push_item(mk(KIND_SW_TOGGLE, '1, '1, '1));
		push_item(mk(KIND_TICK, '1, '1, '1));
		push_item(mk(KIND_TICK, '0, '0, '0));
		push_item(mk(KIND_SW_CLEAR, '0, '0, '0));
		push_item(mk(KIND_SW_ENTER, '0, '0, '0));
		repeat (4) push_item(rand_beat(KIND_TICK));
		// leave while running keeps the mode, leave while stopped drops it
		push_item(mk(KIND_SW_LEAVE, '0, '0, '0));
		push_item(mk(KIND_SW_TOGGLE, '0, '0, '0));
		push_item(mk(KIND_SW_LEAVE, '1, '1, '1));
		// spare codes change nothing
		push_item(mk(KIND_SPARE_LO, '1, '1, '1));
		push_item(mk(KIND_SPARE_HI, '1, '1, '1));
		push_item(mk(KIND_SET_TIME, HOUR_LAST, MIN_LAST, SEC_LAST));
		push_item(mk(KIND_TICK, '0, '0, '0));
	endtask

	// Random segments: tick runs, set-and-run, stopwatch sessions, noise
	task automatic run_random(input int quota);
		int done;
		int pick;
		int len;
		done = 0;
		while (done < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = $urandom_range(5, 50);
				repeat (len) begin
					if ($urandom_range(0, 9) == 0)
						push_item(rand_beat(KIND_W'($urandom_range(2, 7))));
					else
						push_item(rand_beat(KIND_TICK));
				end
				done += len;
			end else if (pick < 70) begin
				len = $urandom_range(21, 130);
				push_item(set_beat());
				repeat (len) push_item(rand_beat(KIND_TICK));
				done += len + 1;
			end else if (pick < 85) begin
				len = $urandom_range(10, 60);
				push_item(rand_beat(KIND_SW_ENTER));
				push_item(rand_beat(KIND_SW_TOGGLE));
				repeat (len) push_item(rand_beat(KIND_TICK));
				if ($urandom_range(0, 4) == 0)
					push_item(rand_beat(KIND_SW_CLEAR));
				push_item(rand_beat(KIND_SW_TOGGLE));
				push_item(rand_beat(KIND_SW_LEAVE));
				done += len + 5;
			end else begin
				len = $urandom_range(1, 8);
				repeat (len) push_item(rand_beat(KIND_W'($urandom_range(0, 7))));
				done += len;
			end
		end
	endtask

	// Output held off while the input keeps offering at full rate
	task automatic long_hold(input int beats);
		hold_req  = 1'b1;
		full_rate = 1'b1;
		repeat (beats) push_item(rand_beat(($urandom_range(0, 3) == 0) ?
			KIND_W'($urandom_range(2, 7)) : KIND_TICK));
		full_rate = 1'b0;
	endtask

	// Main sequence
	initial begin
		sb         = new();
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		kind       = '0;
		set_hour   = '0;
		set_minute = '0;
		set_second = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		configure('0, '0, 1'b1);
		run_directed();
		run_random(PHASE_BEATS);

		drain();
		configure(HOUR_LAST, MIN_LAST, 1'b1);
		run_random(PHASE_BEATS);

		// alarm registers beyond the clock's range never match
		drain();
		configure('1, '1, 1'b1);
		long_hold(20);
		run_random(PHASE_BEATS);

		drain();
		configure(HOUR_LAST, MIN_LAST, 1'b0);
		run_random(PHASE_BEATS);

		drain();
		configure(HOUR_W'($urandom_range(0, 23)), MIN_W'($urandom_range(0, 59)), 1'b1);
		run_random(PHASE_BEATS);

		drain();
		configure('0, '0, 1'b1);
		long_hold(12);
		run_random(PHASE_BEATS);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d beats: %0d ticks, %0d set-time, %0d stopwatch commands, %0d spare",
			n_ticks + n_sets + n_cmds + n_spare, n_ticks, n_sets, n_cmds, n_spare);
		$display("%0d results checked, %0d alarm matches, %0d midnights, %0d settings, %0d holds",
			sb.checked, sb.matches_seen, sb.midnights, n_settings, holds_done);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failures, %0d results owed", sb.mismatches, sb.pending());
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
src/cas_pkg.sv
src/cas_apb_regs.sv
src/cas_time_core.sv
src/clock_alarm_stopwatch_top.sv
src/cas_checker.sv
tb/sv/cas_tb_pkg.sv
tb/sv/tb_top.sv
